@@ rtl/sts_pkg.sv @@
// Shared types and constants for the self-organizing map training block.
// Holds the payload structs, action codes and the controller/datapath command
// types. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sts_pkg;

    localparam int NUM_UNITS    = 16;
    localparam int NUM_FEATURES = 4;
    localparam int NUM_CLASSES  = 4;
    localparam int VALUE_W      = 16;
    localparam int COUNT_W      = 16;

    localparam int UNIT_W    = 4;
    localparam int FEAT_W    = 2;
    localparam int CLASS_W   = 2;
    localparam int EPOCH_W   = 16;
    localparam int WADDR_W   = 6;
    localparam int CADDR_W   = 6;
    localparam int WDEPTH    = NUM_UNITS * NUM_FEATURES;
    localparam int CDEPTH    = NUM_UNITS * NUM_CLASSES;

    // Arithmetic widths.
    localparam int SQ_W      = 2 * (VALUE_W + 1);
    localparam int ROOT_W    = SQ_W / 2;
    localparam int DIST_W    = 18;
    localparam int DIV_NUM_W = 34;
    localparam int DIV_DEN_W = 33;
    localparam int EXP_X_W   = 17;
    localparam int EXP_Y_W   = 18;
    localparam int EXP_W     = 17;
    localparam int RATE_W    = 15;
    localparam int RADIUS_W  = 16;
    localparam int LOG2E_Q15 = 47274;

    // Configuration register indexes.
    localparam logic [1:0] REG_LEARNING_RATE   = 2'd0;
    localparam logic [1:0] REG_NEIGHBOR_RADIUS = 2'd1;
    localparam logic [1:0] REG_EPOCH_LIMIT     = 2'd2;

    localparam logic [RATE_W-1:0]   LEARNING_RATE_RESET   = 15'd3277;
    localparam logic [RADIUS_W-1:0] NEIGHBOR_RADIUS_RESET = 16'd256;
    localparam logic [EPOCH_W-1:0]  EPOCH_LIMIT_RESET     = 16'd100;

    // Result kinds.
    localparam logic RES_TRAIN = 1'b0;
    localparam logic RES_READ  = 1'b1;

    typedef enum logic [1:0] {
        ACT_LOAD   = 2'd0,
        ACT_SAMPLE = 2'd1,
        ACT_CLEAR  = 2'd2,
        ACT_READ   = 2'd3
    } action_t;

    typedef struct packed {
        action_t                    action;
        logic [UNIT_W-1:0]          unit_index;
        logic [FEAT_W-1:0]          element_index;
        logic signed [VALUE_W-1:0]  element_value;
        logic [CLASS_W-1:0]         sample_class;
        logic [EPOCH_W-1:0]         epoch;
    } in_item_t;

    typedef struct packed {
        logic                       result_kind;
        logic [UNIT_W-1:0]          winner_index;
        logic [DIST_W-1:0]          winner_distance;
        logic [COUNT_W-1:0]         class_count;
    } out_item_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_INIT,
        OP_EXP_Y,
        OP_EXP_V,
        OP_RATE,
        OP_MFACT,
        OP_ACC_S,
        OP_ACC_B,
        OP_BEST,
        OP_BW,
        OP_CNT,
        OP_CNT_READ,
        OP_SQRT_BEST,
        OP_SQRT_ACC,
        OP_WDIST,
        OP_DIV_DIST,
        OP_WRITE_W,
        OP_OUT_TRAIN,
        OP_OUT_READ
    } dp_op_t;

    typedef struct packed {
        dp_op_t              op;
        logic                accept;
        logic                first;
        logic                flag;
        logic [FEAT_W-1:0]   feat;
        logic [UNIT_W-1:0]   unit;
        logic [WADDR_W-1:0]  w_addr;
        logic [CADDR_W-1:0]  c_addr;
    } dp_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic sqrt_busy;
        logic better;
    } dp_status_t;

endpackage
`default_nettype wire

@@ rtl/sts_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package dependency.
`timescale 1ns / 1ps
`default_nettype none
module sts_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ rtl/sts_sqrt.sv @@
// Iterative floor integer square root, one result bit per cycle.
// Depends on sts_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none
module sts_sqrt (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire logic [sts_pkg::SQ_W-1:0] radicand,
    output logic busy,
    output logic [sts_pkg::ROOT_W-1:0] root
);
    import sts_pkg::*;

    localparam int REM_W = ROOT_W + 3;
    localparam int CNT_W = $clog2(ROOT_W + 1);

    logic [SQ_W-1:0]   x_reg, x_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              ge;

    always_comb
    begin
        rem_sh    = {rem_reg[REM_W-3:0], x_reg[SQ_W-1 -: 2]};
        trial     = {1'b0, root_reg, 2'b01};
        ge        = rem_sh >= trial;
        x_next    = x_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            x_next    = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CNT_W'(ROOT_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            x_next    = x_reg << 2;
            rem_next  = ge ? rem_sh - trial : rem_sh;
            root_next = {root_reg[ROOT_W-2:0], ge};
            cnt_next  = cnt_reg - 1'b1;
            busy_next = cnt_reg != CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign busy = busy_reg;
    assign root = root_reg;
endmodule
`default_nettype wire

@@ rtl/sts_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Depends on sts_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none
module sts_div (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire logic [sts_pkg::DIV_NUM_W-1:0] dividend,
    input  wire logic [sts_pkg::DIV_DEN_W-1:0] divisor,
    output logic busy,
    output logic [sts_pkg::DIV_NUM_W-1:0] quotient
);
    import sts_pkg::*;

    localparam int CNT_W = $clog2(DIV_NUM_W + 1);

    logic [DIV_NUM_W-1:0] quo_reg, quo_next;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_DEN_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic [DIV_DEN_W:0]   rem_sh;
    logic                 ge;

    always_comb
    begin
        rem_sh    = {rem_reg, quo_reg[DIV_NUM_W-1]};
        ge        = rem_sh >= {1'b0, den_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
            cnt_next  = CNT_W'(DIV_NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? DIV_DEN_W'(rem_sh - {1'b0, den_reg}) : rem_sh[DIV_DEN_W-1:0];
            quo_next  = {quo_reg[DIV_NUM_W-2:0], ge};
            cnt_next  = cnt_reg - 1'b1;
            busy_next = cnt_reg != CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;
endmodule
`default_nettype wire

@@ rtl/sts_datapath.sv @@
// Datapath: configuration registers, weight and counter stores, sample buffer,
// distance, exponential and update arithmetic. Depends on sts_pkg, sts_ram,
// sts_sqrt and sts_div.
`timescale 1ns / 1ps
`default_nettype none
module sts_datapath (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cfg_we,
    input  wire logic [1:0] cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire sts_pkg::in_item_t in_item,
    input  wire sts_pkg::dp_cmd_t cmd,
    output sts_pkg::dp_status_t status,
    output sts_pkg::out_item_t out_item
);
    import sts_pkg::*;

    // Q1.16 table of 2^(-k/16), k = 0..16.
    function automatic logic [EXP_W-1:0] pow2_frac(input logic [4:0] k);
        logic [EXP_W-1:0] v;
        begin
            unique case (k)
                5'd0:    v = 17'd65536;
                5'd1:    v = 17'd62757;
                5'd2:    v = 17'd60097;
                5'd3:    v = 17'd57549;
                5'd4:    v = 17'd55109;
                5'd5:    v = 17'd52773;
                5'd6:    v = 17'd50535;
                5'd7:    v = 17'd48393;
                5'd8:    v = 17'd46341;
                5'd9:    v = 17'd44376;
                5'd10:   v = 17'd42495;
                5'd11:   v = 17'd40693;
                5'd12:   v = 17'd38968;
                5'd13:   v = 17'd37316;
                5'd14:   v = 17'd35734;
                5'd15:   v = 17'd34219;
                default: v = 17'd32768;
            endcase
            return v;
        end
    endfunction

    // First exp stage: scale the argument by log2(e). Arguments past the
    // point where the result underflows to zero are clamped.
    function automatic logic [EXP_Y_W-1:0] exp_scale(input logic [DIV_NUM_W-1:0] q);
        logic [EXP_X_W-1:0]    xc;
        logic [EXP_X_W+15:0]   prod;
        begin
            xc   = (|q[DIV_NUM_W-1:EXP_X_W]) ? '1 : q[EXP_X_W-1:0];
            prod = (EXP_X_W + 16)'(xc) * (EXP_X_W + 16)'(LOG2E_Q15);
            return prod[EXP_X_W+15:15];
        end
    endfunction

    // Second exp stage: interpolate the fraction, then shift by the integer part.
    function automatic logic [EXP_W-1:0] exp_pow(input logic [EXP_Y_W-1:0] y);
        logic [5:0]        n;
        logic [4:0]        k;
        logic [7:0]        r;
        logic [EXP_W-1:0]  tk;
        logic [EXP_W-1:0]  tk1;
        logic [11:0]       diff;
        logic [20:0]       corr;
        logic [EXP_W-1:0]  v;
        begin
            n    = y[17:12];
            k    = {1'b0, y[11:8]};
            r    = y[7:0];
            tk   = pow2_frac(k);
            tk1  = pow2_frac(k + 5'd1);
            diff = 12'(tk - tk1);
            corr = 21'(diff) * 21'(r) + 21'd128;
            v    = tk - EXP_W'(corr[20:8]);
            if (n > 6'd16)
            begin
                return '0;
            end
            return v >> n;
        end
    endfunction

    // Configuration registers.
    logic [RATE_W-1:0]   lr_reg;
    logic [RADIUS_W-1:0] rad_reg;
    logic [EPOCH_W-1:0]  lim_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lr_reg  <= LEARNING_RATE_RESET;
            rad_reg <= NEIGHBOR_RADIUS_RESET;
            lim_reg <= EPOCH_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_LEARNING_RATE)
            begin
                lr_reg <= cfg_data[RATE_W-1:0];
            end
            if (cfg_index == REG_NEIGHBOR_RADIUS)
            begin
                rad_reg <= cfg_data;
            end
            if (cfg_index == REG_EPOCH_LIMIT)
            begin
                lim_reg <= cfg_data;
            end
        end
    end

    // Input decode.
    logic in_feat_ok;
    logic in_unit_ok;
    assign in_feat_ok = int'(in_item.element_index) < NUM_FEATURES;
    assign in_unit_ok = int'(in_item.unit_index) < NUM_UNITS;

    // Weight store.
    logic                      w_we;
    logic [WADDR_W-1:0]        w_waddr;
    logic signed [VALUE_W-1:0] w_wdata;
    logic signed [VALUE_W-1:0] w_rdata;
    logic signed [VALUE_W-1:0] w_new;

    always_comb
    begin
        if (cmd.op == OP_WRITE_W)
        begin
            w_we    = 1'b1;
            w_waddr = cmd.w_addr;
            w_wdata = w_new;
        end
        else
        begin
            w_we    = cmd.accept && in_item.action == ACT_LOAD && in_feat_ok && in_unit_ok;
            w_waddr = WADDR_W'(in_item.unit_index) * WADDR_W'(NUM_FEATURES)
                      + WADDR_W'(in_item.element_index);
            w_wdata = in_item.element_value;
        end
    end

    sts_ram #(
        .WIDTH(VALUE_W),
        .DEPTH(WDEPTH)
    ) u_weight_ram (
        .clk  (clk),
        .we   (w_we),
        .waddr(w_waddr),
        .wdata(w_wdata),
        .raddr(cmd.w_addr),
        .rdata(w_rdata)
    );

    // Class counter store. A counter whose valid bit is clear reads as zero.
    logic               c_we;
    logic [COUNT_W-1:0] c_rdata;
    logic [COUNT_W-1:0] c_cur;
    logic [COUNT_W-1:0] c_inc;
    logic [CDEPTH-1:0]  cvalid_reg;
    logic               cvalid_q_reg;

    assign c_we  = cmd.op == OP_CNT && cmd.flag;
    assign c_cur = cvalid_q_reg ? c_rdata : '0;
    assign c_inc = (c_cur == '1) ? c_cur : c_cur + 1'b1;

    sts_ram #(
        .WIDTH(COUNT_W),
        .DEPTH(CDEPTH)
    ) u_count_ram (
        .clk  (clk),
        .we   (c_we),
        .waddr(cmd.c_addr),
        .wdata(c_inc),
        .raddr(cmd.c_addr),
        .rdata(c_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cvalid_reg   <= '0;
            cvalid_q_reg <= 1'b0;
        end
        else
        begin
            cvalid_q_reg <= cvalid_reg[cmd.c_addr];
            if (cmd.accept && in_item.action == ACT_CLEAR)
            begin
                cvalid_reg <= '0;
            end
            else if (c_we)
            begin
                cvalid_reg[cmd.c_addr] <= 1'b1;
            end
        end
    end

    // Arithmetic units.
    logic [SQ_W-1:0]      acc_reg;
    logic [SQ_W-1:0]      best_sq_reg;
    logic                 sqrt_start;
    logic [SQ_W-1:0]      sqrt_in;
    logic                 sqrt_busy;
    logic [ROOT_W-1:0]    sqrt_root;
    logic                 div_start;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic                 div_busy;
    logic [DIV_NUM_W-1:0] div_quo;
    logic [EPOCH_W-1:0]   ep_reg;
    logic [DIV_DEN_W-1:0] r2_reg;
    logic [EPOCH_W-1:0]   lim_eff;
    logic [RADIUS_W-1:0]  rad_eff;

    assign lim_eff    = (lim_reg == '0) ? EPOCH_W'(1) : lim_reg;
    assign rad_eff    = (rad_reg == '0) ? RADIUS_W'(1) : rad_reg;
    assign sqrt_start = cmd.op == OP_SQRT_BEST || cmd.op == OP_SQRT_ACC;
    assign sqrt_in    = (cmd.op == OP_SQRT_BEST) ? best_sq_reg : acc_reg;
    assign div_start  = cmd.op == OP_INIT || cmd.op == OP_DIV_DIST;

    always_comb
    begin
        if (cmd.op == OP_INIT)
        begin
            div_num = DIV_NUM_W'({ep_reg, 12'd0});
            div_den = DIV_DEN_W'(lim_eff);
        end
        else
        begin
            div_num = DIV_NUM_W'({sqrt_root, 16'd0});
            div_den = r2_reg;
        end
    end

    sts_sqrt u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (sqrt_start),
        .radicand(sqrt_in),
        .busy    (sqrt_busy),
        .root    (sqrt_root)
    );

    sts_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .dividend(div_num),
        .divisor (div_den),
        .busy    (div_busy),
        .quotient(div_quo)
    );

    // Data registers.
    logic signed [VALUE_W-1:0] sample_reg [NUM_FEATURES];
    logic signed [VALUE_W-1:0] bw_reg     [NUM_FEATURES];
    logic signed [VALUE_W-1:0] wcur_reg   [NUM_FEATURES];
    logic [EXP_Y_W-1:0]        y_reg;
    logic [EXP_W-1:0]          e_reg;
    logic [RATE_W-1:0]         rate_reg;
    logic [RATE_W-1:0]         m_reg;
    logic [ROOT_W-1:0]         dist_reg;
    logic [COUNT_W-1:0]        count_reg;
    logic [UNIT_W-1:0]         unit_reg;
    out_item_t                 out_reg;

    logic signed [VALUE_W:0]       d_ref;
    logic signed [VALUE_W:0]       d_diff;
    logic signed [2*VALUE_W+1:0]   d_sq;
    logic [RATE_W+EXP_W-1:0]       scale_prod;
    logic [RATE_W-1:0]             scale_src;
    logic signed [VALUE_W:0]       u_diff;
    logic signed [VALUE_W+RATE_W+1:0] u_prod;
    logic [2*RADIUS_W-1:0]         rad_sq;

    always_comb
    begin
        d_ref      = (cmd.op == OP_ACC_B) ? (VALUE_W+1)'(bw_reg[cmd.feat])
                                          : (VALUE_W+1)'(sample_reg[cmd.feat]);
        d_diff     = d_ref - (VALUE_W+1)'(w_rdata);
        d_sq       = d_diff * d_diff;
        scale_src  = (cmd.op == OP_RATE) ? lr_reg : rate_reg;
        scale_prod = (RATE_W+EXP_W)'(scale_src) * (RATE_W+EXP_W)'(e_reg);
        u_diff     = (VALUE_W+1)'(sample_reg[cmd.feat]) - (VALUE_W+1)'(wcur_reg[cmd.feat]);
        u_prod     = $signed({1'b0, m_reg}) * u_diff;
        w_new      = VALUE_W'((VALUE_W+RATE_W+2)'(wcur_reg[cmd.feat])
                              + (u_prod >>> 15));
        rad_sq     = rad_eff * rad_eff;
    end

    assign status = '{div_busy: div_busy, sqrt_busy: sqrt_busy,
                      better: acc_reg < best_sq_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            unit_reg <= in_item.unit_index;
            if (in_item.action == ACT_SAMPLE && in_feat_ok)
            begin
                sample_reg[in_item.element_index] <= in_item.element_value;
                ep_reg <= in_item.epoch;
            end
        end
        unique case (cmd.op)
            OP_INIT:
            begin
                r2_reg <= {rad_sq, 1'b0};
            end
            OP_EXP_Y:
            begin
                y_reg <= exp_scale(div_quo);
            end
            OP_EXP_V:
            begin
                e_reg <= exp_pow(y_reg);
            end
            OP_RATE:
            begin
                rate_reg <= scale_prod[RATE_W+15:16];
            end
            OP_MFACT:
            begin
                m_reg <= scale_prod[RATE_W+15:16];
            end
            OP_ACC_S:
            begin
                acc_reg <= (cmd.first ? '0 : acc_reg) + SQ_W'(d_sq);
            end
            OP_ACC_B:
            begin
                acc_reg <= (cmd.first ? '0 : acc_reg) + SQ_W'(d_sq);
                wcur_reg[cmd.feat] <= w_rdata;
            end
            OP_BEST:
            begin
                best_sq_reg <= acc_reg;
            end
            OP_BW:
            begin
                bw_reg[cmd.feat] <= w_rdata;
            end
            OP_CNT:
            begin
                count_reg <= cmd.flag ? c_inc : '0;
            end
            OP_CNT_READ:
            begin
                count_reg <= cmd.flag ? c_cur : '0;
            end
            OP_WDIST:
            begin
                dist_reg <= sqrt_root;
            end
            OP_OUT_TRAIN:
            begin
                out_reg.result_kind     <= RES_TRAIN;
                out_reg.winner_index    <= cmd.unit;
                out_reg.winner_distance <= DIST_W'(dist_reg);
                out_reg.class_count     <= count_reg;
            end
            OP_OUT_READ:
            begin
                out_reg.result_kind     <= RES_READ;
                out_reg.winner_index    <= unit_reg;
                out_reg.winner_distance <= '0;
                out_reg.class_count     <= count_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign out_item = out_reg;
endmodule
`default_nettype wire

@@ rtl/sts_ctrl.sv @@
// Controller: sequences item handling and the two passes of a training step
// over the units, and owns the handshake state. Depends on sts_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sts_ctrl (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic in_stall,
    input  wire sts_pkg::in_item_t in_item,
    output logic out_valid,
    input  wire logic out_stall,
    input  wire sts_pkg::dp_status_t status,
    output sts_pkg::dp_cmd_t cmd
);
    import sts_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_READ_WAIT,
        ST_READ_OUT,
        ST_INIT,
        ST_EP_DIV,
        ST_EP_Y,
        ST_EP_V,
        ST_RATE,
        ST_P1_RD,
        ST_P1_ACC,
        ST_P1_CMP,
        ST_CNT_RD,
        ST_CNT_WR,
        ST_BW_RD,
        ST_BW_CAP,
        ST_WSQ_GO,
        ST_WSQ_WAIT,
        ST_P2_RD,
        ST_P2_ACC,
        ST_P2_SQ_GO,
        ST_P2_SQ_WAIT,
        ST_P2_DIV_WAIT,
        ST_P2_Y,
        ST_P2_V,
        ST_P2_M,
        ST_P2_WR,
        ST_TRAIN_OUT
    } state_t;

    function automatic logic [WADDR_W-1:0] w_addr_of(input logic [UNIT_W-1:0] u,
                                                     input logic [FEAT_W-1:0] f);
        return WADDR_W'(u) * WADDR_W'(NUM_FEATURES) + WADDR_W'(f);
    endfunction

    function automatic logic [CADDR_W-1:0] c_addr_of(input logic [UNIT_W-1:0] u,
                                                     input logic [CLASS_W-1:0] c);
        return CADDR_W'(u) * CADDR_W'(NUM_CLASSES) + CADDR_W'(c);
    endfunction

    state_t             state_reg, state_next;
    logic [UNIT_W-1:0]  u_reg, u_next;
    logic [FEAT_W-1:0]  f_reg, f_next;
    logic [UNIT_W-1:0]  bmu_reg, bmu_next;
    logic [CLASS_W-1:0] cls_reg, cls_next;
    logic               rd_ok_reg, rd_ok_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_free;
    logic               last_feat;
    logic               last_unit;
    logic               cls_ok;

    assign out_free  = !out_valid_reg || !out_stall;
    assign last_feat = int'(f_reg) == NUM_FEATURES - 1;
    assign last_unit = int'(u_reg) == NUM_UNITS - 1;
    assign cls_ok    = int'(cls_reg) < NUM_CLASSES;

    always_comb
    begin
        state_next     = state_reg;
        u_next         = u_reg;
        f_next         = f_reg;
        bmu_next       = bmu_reg;
        cls_next       = cls_reg;
        rd_ok_next     = rd_ok_reg;
        out_valid_next = out_valid_reg && out_stall;

        cmd        = '0;
        cmd.op     = OP_NONE;
        cmd.feat   = f_reg;
        cmd.unit   = bmu_reg;
        cmd.first  = f_reg == '0;
        cmd.w_addr = w_addr_of(u_reg, f_reg);
        cmd.c_addr = c_addr_of(bmu_reg, cls_reg);

        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.accept = in_valid;
                cmd.c_addr = c_addr_of(in_item.unit_index, in_item.element_index);
                if (in_valid)
                begin
                    unique case (in_item.action)
                        ACT_SAMPLE:
                        begin
                            if (int'(in_item.element_index) == NUM_FEATURES - 1)
                            begin
                                cls_next   = in_item.sample_class;
                                u_next     = '0;
                                f_next     = '0;
                                state_next = ST_INIT;
                            end
                        end
                        ACT_READ:
                        begin
                            rd_ok_next = int'(in_item.unit_index) < NUM_UNITS
                                         && int'(in_item.element_index) < NUM_CLASSES;
                            state_next = ST_READ_WAIT;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_READ_WAIT:
            begin
                cmd.op     = OP_CNT_READ;
                cmd.flag   = rd_ok_reg;
                state_next = ST_READ_OUT;
            end
            ST_READ_OUT:
            begin
                if (out_free)
                begin
                    cmd.op         = OP_OUT_READ;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_INIT:
            begin
                cmd.op     = OP_INIT;
                state_next = ST_EP_DIV;
            end
            ST_EP_DIV:
            begin
                if (!status.div_busy)
                begin
                    state_next = ST_EP_Y;
                end
            end
            ST_EP_Y:
            begin
                cmd.op     = OP_EXP_Y;
                state_next = ST_EP_V;
            end
            ST_EP_V:
            begin
                cmd.op     = OP_EXP_V;
                state_next = ST_RATE;
            end
            ST_RATE:
            begin
                cmd.op     = OP_RATE;
                state_next = ST_P1_RD;
            end
            ST_P1_RD:
            begin
                state_next = ST_P1_ACC;
            end
            ST_P1_ACC:
            begin
                cmd.op = OP_ACC_S;
                if (last_feat)
                begin
                    f_next     = '0;
                    state_next = ST_P1_CMP;
                end
                else
                begin
                    f_next     = f_reg + 1'b1;
                    state_next = ST_P1_RD;
                end
            end
            ST_P1_CMP:
            begin
                // Strict compare keeps the lower index on a tie.
                if (u_reg == '0 || status.better)
                begin
                    cmd.op   = OP_BEST;
                    bmu_next = u_reg;
                end
                if (last_unit)
                begin
                    u_next     = '0;
                    state_next = ST_CNT_RD;
                end
                else
                begin
                    u_next     = u_reg + 1'b1;
                    state_next = ST_P1_RD;
                end
            end
            ST_CNT_RD:
            begin
                state_next = ST_CNT_WR;
            end
            ST_CNT_WR:
            begin
                cmd.op     = OP_CNT;
                cmd.flag   = cls_ok;
                state_next = ST_BW_RD;
            end
            ST_BW_RD:
            begin
                cmd.w_addr = w_addr_of(bmu_reg, f_reg);
                state_next = ST_BW_CAP;
            end
            ST_BW_CAP:
            begin
                cmd.op = OP_BW;
                if (last_feat)
                begin
                    f_next     = '0;
                    state_next = ST_WSQ_GO;
                end
                else
                begin
                    f_next     = f_reg + 1'b1;
                    state_next = ST_BW_RD;
                end
            end
            ST_WSQ_GO:
            begin
                cmd.op     = OP_SQRT_BEST;
                state_next = ST_WSQ_WAIT;
            end
            ST_WSQ_WAIT:
            begin
                if (!status.sqrt_busy)
                begin
                    cmd.op     = OP_WDIST;
                    state_next = ST_P2_RD;
                end
            end
            ST_P2_RD:
            begin
                state_next = ST_P2_ACC;
            end
            ST_P2_ACC:
            begin
                cmd.op = OP_ACC_B;
                if (last_feat)
                begin
                    f_next     = '0;
                    state_next = ST_P2_SQ_GO;
                end
                else
                begin
                    f_next     = f_reg + 1'b1;
                    state_next = ST_P2_RD;
                end
            end
            ST_P2_SQ_GO:
            begin
                cmd.op     = OP_SQRT_ACC;
                state_next = ST_P2_SQ_WAIT;
            end
            ST_P2_SQ_WAIT:
            begin
                if (!status.sqrt_busy)
                begin
                    cmd.op     = OP_DIV_DIST;
                    state_next = ST_P2_DIV_WAIT;
                end
            end
            ST_P2_DIV_WAIT:
            begin
                if (!status.div_busy)
                begin
                    state_next = ST_P2_Y;
                end
            end
            ST_P2_Y:
            begin
                cmd.op     = OP_EXP_Y;
                state_next = ST_P2_V;
            end
            ST_P2_V:
            begin
                cmd.op     = OP_EXP_V;
                state_next = ST_P2_M;
            end
            ST_P2_M:
            begin
                cmd.op     = OP_MFACT;
                state_next = ST_P2_WR;
            end
            ST_P2_WR:
            begin
                cmd.op = OP_WRITE_W;
                if (last_feat)
                begin
                    f_next = '0;
                    if (last_unit)
                    begin
                        u_next     = '0;
                        state_next = ST_TRAIN_OUT;
                    end
                    else
                    begin
                        u_next     = u_reg + 1'b1;
                        state_next = ST_P2_RD;
                    end
                end
                else
                begin
                    f_next = f_reg + 1'b1;
                end
            end
            ST_TRAIN_OUT:
            begin
                if (out_free)
                begin
                    cmd.op         = OP_OUT_TRAIN;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            u_reg         <= '0;
            f_reg         <= '0;
            bmu_reg       <= '0;
            cls_reg       <= '0;
            rd_ok_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            u_reg         <= u_next;
            f_reg         <= f_next;
            bmu_reg       <= bmu_next;
            cls_reg       <= cls_next;
            rd_ok_reg     <= rd_ok_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = state_reg != ST_IDLE;
    assign out_valid = out_valid_reg;
endmodule
`default_nettype wire

@@ rtl/som_training_step_top.sv @@
// Top level of the self-organizing map trainer: the controller and the datapath.
// Depends on sts_pkg, sts_ctrl and sts_datapath.
//
// Usage: input transactions carry an action. A weight load writes one element
// of the weight store, a clear zeroes every class counter, and a sample
// feature fills the sample buffer; the last feature starts a training step
// that returns one result transaction (winner, distance, bumped counter).
// A counter read returns one result transaction holding the counter.
// Loads, clears and non-final features are taken without stalling. A read
// passes a wait state for the counter store and then an output state. A
// training step runs one epoch division, a distance pass over every unit and
// an update pass over every unit, paced by the bit-serial square root and
// the bit-serial divider shared by every unit.
// Items are taken one at a time; input stall is high while an item is at
// work. The result sits in an output register, so the next item is accepted
// while an earlier result still waits; if the receiver keeps stalling, a new
// result holds in the block until the register frees up.
// Reset clears all class counters and restores the configuration defaults;
// weights and the sample buffer must be written before use. Configuration
// writes through cfg_we belong in idle time.
`timescale 1ns / 1ps
`default_nettype none
module som_training_step_top (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [15:0]       cfg_data,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire sts_pkg::in_item_t in_item,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output sts_pkg::out_item_t     out_item
);
    import sts_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    sts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status   (status),
        .cmd      (cmd)
    );

    sts_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .in_item  (in_item),
        .cmd      (cmd),
        .status   (status),
        .out_item (out_item)
    );
endmodule
`default_nettype wire
